[rtl/qrs_pkg.sv]
// Shared package for the quadratic root solver.
// Holds the default widths, the root-kind codes and the control struct.
// No dependencies.
`default_nettype none

package qrs_pkg;

    // Default number format: signed Q16.16.
    localparam int QRS_DATA_WIDTH = 32;
    localparam int QRS_FRAC_BITS  = 16;

    // Width of the zero tolerance register.
    localparam int QRS_TOL_WIDTH  = 16;

    // Depth of the queue between the front and back halves.
    localparam int QRS_FIFO_DEPTH = 4;

    // Root-kind codes.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_ONE     = 3'd1;
    localparam logic [2:0] KIND_TWO     = 3'd2;
    localparam logic [2:0] KIND_COMPLEX = 3'd3;
    localparam logic [2:0] KIND_INF     = 3'd4;

    // Per-item control that travels from the front half to the back half.
    typedef struct packed {
        logic [2:0] kind;
        logic       use_one;
        logic       use_two;
    } qrs_ctrl_t;

endpackage

`default_nettype wire

[rtl/quadratic_root_solver_unit.sv]
// Quadratic root solver, top level: front half, queue and back half.
// Depends on qrs_pkg, qrs_front, qrs_fifo, qrs_back and qrs_div.
//
// Usage: coefficient sets a, b, c (signed, FRAC_BITS fraction bits, Q16.16 by
// default) enter on the s_ channel, one beat per set. Each set yields one
// result beat on the m_ channel: root kind, two roots and a saturation flag,
// in input order. The zero tolerance register is written through
// cfg_valid/cfg_data while the block is idle; cfg_ready is always high.
// A set passes the front half with its DATA_WIDTH + 2 square root stages,
// the queue, and the back half with its DATA_WIDTH + 2 + FRAC_BITS divider
// stages. Throughput is one set per cycle while m_ready stays high.
// Reset (aresetn low, synchronous) empties every stage and the queue and sets
// the tolerance to zero. When the receiver stalls, the back half holds, the
// queue fills, and then the front half holds and drops s_ready.
`default_nettype none

module quadratic_root_solver_unit import qrs_pkg::*; #(
    parameter int DATA_WIDTH = QRS_DATA_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic [QRS_TOL_WIDTH-1:0]     cfg_data,
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_coef_a,
    input  wire logic signed [DATA_WIDTH-1:0] s_coef_b,
    input  wire logic signed [DATA_WIDTH-1:0] s_coef_c,
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic [2:0]                   m_root_kind,
    output      logic signed [DATA_WIDTH-1:0] m_root_one,
    output      logic signed [DATA_WIDTH-1:0] m_root_two,
    output      logic                         m_saturated
);

    localparam int NS  = DATA_WIDTH + 4;
    localparam int DW  = DATA_WIDTH + 1;
    localparam int QDW = $bits(qrs_ctrl_t) + 2 + 2 * DW + 2 * NS;

    // Zero tolerance register.
    logic [QRS_TOL_WIDTH-1:0] zero_tolerance_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_tolerance_reg <= '0;
        end else if (cfg_valid) begin
            zero_tolerance_reg <= cfg_data;
        end
    end

    // Front half.
    logic          f_valid, f_ready;
    logic [NS-1:0] f_num_one, f_num_two;
    logic [DW-1:0] f_den_one, f_den_two;
    logic          f_dneg_one, f_dneg_two;
    qrs_ctrl_t     f_ctrl;

    qrs_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coef_a     (s_coef_a),
        .s_coef_b     (s_coef_b),
        .s_coef_c     (s_coef_c),
        .tol          (zero_tolerance_reg),
        .out_valid    (f_valid),
        .out_ready    (f_ready),
        .out_num_one  (f_num_one),
        .out_num_two  (f_num_two),
        .out_den_one  (f_den_one),
        .out_den_two  (f_den_two),
        .out_dneg_one (f_dneg_one),
        .out_dneg_two (f_dneg_two),
        .out_ctrl     (f_ctrl)
    );

    // Queue between the halves.
    logic [QDW-1:0] q_wr_data, q_rd_data;
    logic           q_rd_valid, q_rd_ready;
    logic [NS-1:0]  b_num_one, b_num_two;
    logic [DW-1:0]  b_den_one, b_den_two;
    logic           b_dneg_one, b_dneg_two;
    qrs_ctrl_t      b_ctrl;

    assign q_wr_data = {f_ctrl, f_dneg_one, f_dneg_two, f_den_one, f_den_two,
                        f_num_one, f_num_two};
    assign {b_ctrl, b_dneg_one, b_dneg_two, b_den_one, b_den_two,
            b_num_one, b_num_two} = q_rd_data;

    qrs_fifo #(
        .WIDTH (QDW),
        .DEPTH (QRS_FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    // Back half.
    qrs_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_rd_valid),
        .in_ready    (q_rd_ready),
        .in_num_one  (b_num_one),
        .in_num_two  (b_num_two),
        .in_den_one  (b_den_one),
        .in_den_two  (b_den_two),
        .in_dneg_one (b_dneg_one),
        .in_dneg_two (b_dneg_two),
        .in_ctrl     (b_ctrl),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_root_kind (m_root_kind),
        .m_root_one  (m_root_one),
        .m_root_two  (m_root_two),
        .m_saturated (m_saturated)
    );

`ifndef SYNTH
    // Kinds without roots carry zero roots and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_root_kind == KIND_NONE || m_root_kind == KIND_INF)
        |-> m_root_one == '0 && m_root_two == '0 && !m_saturated)
        else $error("root fields set for a kind without roots");

    // A single root leaves the second field at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_kind == KIND_ONE |-> m_root_two == '0)
        else $error("second root set for a single-root result");

    // The front half only holds off input when the queue is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> f_valid && !f_ready)
        else $error("input stalled while the queue has room");
`endif

endmodule

`default_nettype wire

[rtl/qrs_div.sv]
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Used by the back half for the fixed-point quotients; depends on qrs_pkg.
`default_nettype none

module qrs_div import qrs_pkg::*; #(
    parameter int NUM_W = QRS_DATA_WIDTH + 2 + QRS_FRAC_BITS,
    parameter int DEN_W = QRS_DATA_WIDTH + 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output      logic [NUM_W-1:0] quo
);

    localparam int REM_W = DEN_W + 1;

    logic [NUM_W-1:0] x_reg [NUM_W];
    logic [NUM_W-1:0] q_reg [NUM_W];
    logic [DEN_W-1:0] r_reg [NUM_W];
    logic [DEN_W-1:0] d_reg [NUM_W];

    // One stage per quotient bit, most significant first.
    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [NUM_W-1:0] x_in;
        logic [NUM_W-1:0] q_in;
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] diff;
        logic             ge;

        if (i == 0) begin : g_first
            assign x_in = num;
            assign q_in = '0;
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_next
            assign x_in = x_reg[i-1];
            assign q_in = q_reg[i-1];
            assign r_in = r_reg[i-1];
            assign d_in = d_reg[i-1];
        end

        // Shift in the next dividend bit and try to subtract the divisor.
        assign trial = {r_in, x_in[NUM_W-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= {x_in[NUM_W-2:0], 1'b0};
                q_reg[i] <= {q_in[NUM_W-2:0], ge};
                r_reg[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                d_reg[i] <= d_in;
            end
        end
    end

    assign quo = q_reg[NUM_W-1];

endmodule

`default_nettype wire

[rtl/qrs_front.sv]
// Front half of the quadratic root solver: magnitudes, discriminant,
// classification, pipelined square root and quotient operands. Depends on qrs_pkg.
`default_nettype none

module qrs_front import qrs_pkg::*; #(
    parameter int DATA_WIDTH = QRS_DATA_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_coef_a,
    input  wire logic signed [DATA_WIDTH-1:0] s_coef_b,
    input  wire logic signed [DATA_WIDTH-1:0] s_coef_c,
    input  wire logic [QRS_TOL_WIDTH-1:0]     tol,
    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic [DATA_WIDTH+3:0]        out_num_one,
    output      logic [DATA_WIDTH+3:0]        out_num_two,
    output      logic [DATA_WIDTH:0]          out_den_one,
    output      logic [DATA_WIDTH:0]          out_den_two,
    output      logic                         out_dneg_one,
    output      logic                         out_dneg_two,
    output      qrs_ctrl_t                    out_ctrl
);

    localparam int W   = DATA_WIDTH;
    localparam int SW  = W + 2;          // square root width
    localparam int NS  = W + 4;          // signed numerator width
    localparam int DMW = 2 * W + 3;      // discriminant magnitude width
    localparam int X2  = 2 * SW;         // padded radicand width
    localparam int ABW = 3 * W + 3;      // coefficient sideband width
    localparam int SBW = ABW + 4;        // sideband plus kind and linear flag

    logic en;

    // The whole front pipeline moves when its last stage can hand off.
    logic op_valid_reg;
    assign en      = !op_valid_reg || out_ready;
    assign s_ready = en;

    // Stage 1: magnitudes and signs of the coefficients.
    logic           v1_reg;
    logic [W-1:0]   mag_a_reg, mag_b_reg, mag_c_reg;
    logic           neg_a_reg, neg_b_reg, neg_c_reg;
    logic [W-1:0]   ua, ub, uc;

    assign ua = s_coef_a;
    assign ub = s_coef_b;
    assign uc = s_coef_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg <= ua[W-1] ? -ua : ua;
            mag_b_reg <= ub[W-1] ? -ub : ub;
            mag_c_reg <= uc[W-1] ? -uc : uc;
            neg_a_reg <= ua[W-1];
            neg_b_reg <= ub[W-1];
            neg_c_reg <= uc[W-1];
        end
    end

    // Stage 2: the two products and the near-zero tests.
    logic           v2_reg;
    logic [2*W-1:0] bb_reg, ac_reg;
    logic           nz_a_reg, nz_b_reg, nz_c_reg;
    logic [ABW-1:0] ab2_reg;
    logic [W-1:0]   tol_w;

    assign tol_w = {{(W-QRS_TOL_WIDTH){1'b0}}, tol};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb_reg   <= (2*W)'(mag_b_reg) * (2*W)'(mag_b_reg);
            ac_reg   <= (2*W)'(mag_a_reg) * (2*W)'(mag_c_reg);
            nz_a_reg <= (mag_a_reg <= tol_w);
            nz_b_reg <= (mag_b_reg <= tol_w);
            nz_c_reg <= (mag_c_reg <= tol_w);
            ab2_reg  <= {neg_a_reg, neg_b_reg, neg_c_reg, mag_a_reg, mag_b_reg, mag_c_reg};
        end
    end

    // Stage 3: discriminant magnitude and sign, exact at double width.
    logic           v3_reg;
    logic [DMW-1:0] dmag3_reg;
    logic           dneg3_reg;
    logic           nz_a3_reg, nz_b3_reg, nz_c3_reg;
    logic [ABW-1:0] ab3_reg;
    logic [DMW-1:0] bbx, acx;
    logic           signs_differ;

    assign bbx          = {3'b000, bb_reg};
    assign acx          = {1'b0, ac_reg, 2'b00};
    assign signs_differ = ab2_reg[ABW-1] != ab2_reg[ABW-3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (signs_differ) begin
                dmag3_reg <= bbx + acx;
                dneg3_reg <= 1'b0;
            end else if (bbx >= acx) begin
                dmag3_reg <= bbx - acx;
                dneg3_reg <= 1'b0;
            end else begin
                dmag3_reg <= acx - bbx;
                dneg3_reg <= 1'b1;
            end
            nz_a3_reg <= nz_a_reg;
            nz_b3_reg <= nz_b_reg;
            nz_c3_reg <= nz_c_reg;
            ab3_reg   <= ab2_reg;
        end
    end

    // Stage 4: classify the item.
    logic           v4_reg;
    logic [DMW-1:0] dmag4_reg;
    logic [2:0]     kind4_reg;
    logic           lin4_reg;
    logic [ABW-1:0] ab4_reg;
    logic [DMW-1:0] tol_d;
    logic           d_zero;

    assign tol_d  = {{(DMW-QRS_TOL_WIDTH-FRAC_BITS){1'b0}}, tol, {FRAC_BITS{1'b0}}};
    assign d_zero = (dmag3_reg <= tol_d);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag4_reg <= dmag3_reg;
            lin4_reg  <= nz_a3_reg;
            ab4_reg   <= ab3_reg;
            if (nz_a3_reg) begin
                if (!nz_b3_reg) begin
                    kind4_reg <= KIND_ONE;
                end else if (!nz_c3_reg) begin
                    kind4_reg <= KIND_NONE;
                end else begin
                    kind4_reg <= KIND_INF;
                end
            end else if (d_zero) begin
                kind4_reg <= KIND_ONE;
            end else if (dneg3_reg) begin
                kind4_reg <= KIND_COMPLEX;
            end else begin
                kind4_reg <= KIND_TWO;
            end
        end
    end

    // Square root pipeline: one result bit per stage, two radicand bits in.
    logic [X2-1:0]   sx_reg   [SW];
    logic [SW+1:0]   srem_reg [SW];
    logic [SW-1:0]   sroot_reg[SW];
    logic [SBW-1:0]  sside_reg[SW];
    logic            sv_reg   [SW];

    for (genvar i = 0; i < SW; i++) begin : g_sqrt
        logic [X2-1:0]  x_in;
        logic [SW+1:0]  rem_in;
        logic [SW-1:0]  root_in;
        logic [SBW-1:0] side_in;
        logic           v_in;
        logic [SW+1:0]  rem_sh;
        logic [SW+1:0]  trial;
        logic           ge;

        if (i == 0) begin : g_first
            assign x_in    = {1'b0, dmag4_reg};
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = {lin4_reg, kind4_reg, ab4_reg};
            assign v_in    = v4_reg;
        end else begin : g_next
            assign x_in    = sx_reg[i-1];
            assign rem_in  = srem_reg[i-1];
            assign root_in = sroot_reg[i-1];
            assign side_in = sside_reg[i-1];
            assign v_in    = sv_reg[i-1];
        end

        assign rem_sh = {rem_in[SW-1:0], x_in[X2-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[i] <= 1'b0;
            end else if (en) begin
                sv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sx_reg[i]    <= {x_in[X2-3:0], 2'b00};
                srem_reg[i]  <= ge ? rem_sh - trial : rem_sh;
                sroot_reg[i] <= {root_in[SW-2:0], ge};
                sside_reg[i] <= side_in;
            end
        end
    end

    // Operand stage: signed numerators and divisor magnitudes per case.
    logic [SBW-1:0] side_l;
    logic           lin_l;
    logic [2:0]     kind_l;
    logic           neg_a_l, neg_b_l, neg_c_l;
    logic [W-1:0]   mag_a_l, mag_b_l, mag_c_l;
    logic [SW-1:0]  root_l;
    logic [NS-1:0]  neg_b_num, neg_c_num, s_num;
    logic [W:0]     den_a2, den_b;
    logic [NS-1:0]  num_one_next, num_two_next;
    logic [W:0]     den_one_next;
    logic           dneg_one_next, dneg_two_next;
    qrs_ctrl_t      ctrl_next;

    assign side_l  = sside_reg[SW-1];
    assign root_l  = sroot_reg[SW-1];
    assign lin_l   = side_l[SBW-1];
    assign kind_l  = side_l[SBW-2 -: 3];
    assign neg_a_l = side_l[ABW-1];
    assign neg_b_l = side_l[ABW-2];
    assign neg_c_l = side_l[ABW-3];
    assign mag_a_l = side_l[3*W-1 -: W];
    assign mag_b_l = side_l[2*W-1 -: W];
    assign mag_c_l = side_l[W-1:0];

    // -b and -c as signed numerators, and the root as a positive one.
    assign neg_b_num = neg_b_l ? {{(NS-W){1'b0}}, mag_b_l} : -{{(NS-W){1'b0}}, mag_b_l};
    assign neg_c_num = neg_c_l ? {{(NS-W){1'b0}}, mag_c_l} : -{{(NS-W){1'b0}}, mag_c_l};
    assign s_num     = {2'b00, root_l};
    assign den_a2    = {mag_a_l, 1'b0};
    assign den_b     = {1'b0, mag_b_l};

    // Pick the quotient operands for the root kind.
    always_comb begin
        ctrl_next.kind = kind_l;
        num_one_next   = neg_b_num;
        num_two_next   = '0;
        den_one_next   = den_a2;
        dneg_one_next  = neg_a_l;
        dneg_two_next  = neg_a_l;
        case (kind_l)
            KIND_ONE: begin
                ctrl_next.use_one = 1'b1;
                ctrl_next.use_two = 1'b0;
                if (lin_l) begin
                    num_one_next  = neg_c_num;
                    den_one_next  = den_b;
                    dneg_one_next = neg_b_l;
                end
            end
            KIND_TWO: begin
                ctrl_next.use_one = 1'b1;
                ctrl_next.use_two = 1'b1;
                num_one_next      = neg_b_num + s_num;
                num_two_next      = neg_b_num - s_num;
            end
            KIND_COMPLEX: begin
                ctrl_next.use_one = 1'b1;
                ctrl_next.use_two = 1'b1;
                num_two_next      = s_num;
                dneg_two_next     = 1'b0;
            end
            default: begin
                ctrl_next.use_one = 1'b0;
                ctrl_next.use_two = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
        end else if (en) begin
            op_valid_reg <= sv_reg[SW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctrl     <= ctrl_next;
            out_den_one  <= den_one_next;
            out_den_two  <= den_a2;
            out_dneg_one <= dneg_one_next;
            out_dneg_two <= dneg_two_next;
            out_num_one  <= num_one_next;
            out_num_two  <= num_two_next;
        end
    end

    assign out_valid = op_valid_reg;

endmodule

`default_nettype wire

[rtl/qrs_fifo.sv]
// Small first-word-fall-through queue between the front and back halves.
// Depends on qrs_pkg for the default depth.
`default_nettype none

module qrs_fifo import qrs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QRS_FIFO_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output      logic             wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output      logic             rd_valid,
    input  wire logic             rd_ready,
    output      logic [WIDTH-1:0] rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/qrs_back.sv]
// Back half of the quadratic root solver: two pipelined dividers, saturation
// and the output register. Depends on qrs_pkg and qrs_div.
`default_nettype none

module qrs_back import qrs_pkg::*; #(
    parameter int DATA_WIDTH = QRS_DATA_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic [DATA_WIDTH+3:0]        in_num_one,
    input  wire logic [DATA_WIDTH+3:0]        in_num_two,
    input  wire logic [DATA_WIDTH:0]          in_den_one,
    input  wire logic [DATA_WIDTH:0]          in_den_two,
    input  wire logic                         in_dneg_one,
    input  wire logic                         in_dneg_two,
    input  wire qrs_ctrl_t                    in_ctrl,
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic [2:0]                   m_root_kind,
    output      logic signed [DATA_WIDTH-1:0] m_root_one,
    output      logic signed [DATA_WIDTH-1:0] m_root_two,
    output      logic                         m_saturated
);

    localparam int W   = DATA_WIDTH;
    localparam int NS  = W + 4;
    localparam int NW  = W + 2;
    localparam int QW  = NW + FRAC_BITS;
    localparam int SDW = $bits(qrs_ctrl_t) + 2;  // control struct plus two sign bits

    logic en;
    logic m_valid_reg;

    // The back pipeline moves whenever the output register is free or taken.
    assign en       = !m_valid_reg || m_ready;
    assign in_ready = en;

    // Saturate a quotient magnitude and apply its sign; bit W is the flag.
    function automatic logic [W:0] fix_quotient(input logic [QW-1:0] q, input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] qs;
        logic         sat;
        lim = {neg, {(W-1){~neg}}};
        sat = (q > {{(QW-W){1'b0}}, lim});
        qs  = sat ? lim : q[W-1:0];
        return {sat, neg ? -qs : qs};
    endfunction

    // Entry stage: numerator magnitudes scaled by the fraction bits.
    logic            b0_valid_reg;
    logic [QW-1:0]   num1_reg, num2_reg;
    logic [W:0]      den1_reg, den2_reg;
    logic [SDW-1:0]  side0_reg;
    logic [NS-1:0]   nmag1, nmag2;

    assign nmag1 = in_num_one[NS-1] ? -in_num_one : in_num_one;
    assign nmag2 = in_num_two[NS-1] ? -in_num_two : in_num_two;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
        end else if (en) begin
            b0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num1_reg  <= {nmag1[NW-1:0], {FRAC_BITS{1'b0}}};
            num2_reg  <= {nmag2[NW-1:0], {FRAC_BITS{1'b0}}};
            den1_reg  <= in_den_one;
            den2_reg  <= in_den_two;
            side0_reg <= {in_ctrl, in_num_one[NS-1] ^ in_dneg_one,
                          in_num_two[NS-1] ^ in_dneg_two};
        end
    end

    // Dividers.
    logic [QW-1:0] quo1, quo2;

    qrs_div #(
        .NUM_W (QW),
        .DEN_W (W + 1)
    ) u_div_one (
        .aclk (aclk),
        .en   (en),
        .num  (num1_reg),
        .den  (den1_reg),
        .quo  (quo1)
    );

    qrs_div #(
        .NUM_W (QW),
        .DEN_W (W + 1)
    ) u_div_two (
        .aclk (aclk),
        .en   (en),
        .num  (num2_reg),
        .den  (den2_reg),
        .quo  (quo2)
    );

    // Valid bits and control that run alongside the divider stages.
    logic           dv_reg   [QW];
    logic [SDW-1:0] dside_reg[QW];

    for (genvar i = 0; i < QW; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i] <= 1'b0;
            end else if (en) begin
                dv_reg[i] <= (i == 0) ? b0_valid_reg : dv_reg[(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dside_reg[i] <= (i == 0) ? side0_reg : dside_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // Output register.
    qrs_ctrl_t   ctrl_l;
    logic        neg1_l, neg2_l;
    logic [W:0]  fix1, fix2;

    assign {ctrl_l, neg1_l, neg2_l} = dside_reg[QW-1];
    assign fix1 = fix_quotient(quo1, neg1_l);
    assign fix2 = fix_quotient(quo2, neg2_l);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_root_kind <= ctrl_l.kind;
            m_root_one  <= ctrl_l.use_one ? fix1[W-1:0] : '0;
            m_root_two  <= ctrl_l.use_two ? fix2[W-1:0] : '0;
            m_saturated <= (ctrl_l.use_one && fix1[W]) || (ctrl_l.use_two && fix2[W]);
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[test/qrs_checker.sv]
// Checker for the quadratic root solver: watches the config, input and result channels,
// predicts each result and compares it field by field with what the block returns.
// Depends on qrs_pkg.
module qrs_checker import qrs_pkg::*; (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [QRS_TOL_WIDTH-1:0]         cfg_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic signed [QRS_DATA_WIDTH-1:0] s_coef_a,
    input  logic signed [QRS_DATA_WIDTH-1:0] s_coef_b,
    input  logic signed [QRS_DATA_WIDTH-1:0] s_coef_c,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [2:0]                       m_root_kind,
    input  logic signed [QRS_DATA_WIDTH-1:0] m_root_one,
    input  logic signed [QRS_DATA_WIDTH-1:0] m_root_two,
    input  logic                             m_saturated,
    output int                               fail_count,
    output int                               roots_pending,
    output int                               roots_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] one;
        logic [31:0] two;
        logic        sat;
    } roots_t;

    roots_t                   expected_roots[$];
    logic [QRS_TOL_WIDTH-1:0] tolerance;
    int                       mismatches;
    int                       checked;

    assign fail_count    = mismatches;
    assign roots_pending = expected_roots.size();
    assign roots_checked = checked;

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    // Floor of the square root of a 128-bit value, found bit by bit.
    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= n) r = cand;
        end
        return r;
    endfunction

    // Fixed-point quotient num/den, rounded toward zero and saturated to 32 bits.
    function automatic logic [31:0] fixed_quotient(longint num, longint den, ref logic sat);
        logic         neg;
        logic [63:0]  lim;
        logic [63:0]  qq;
        logic [127:0] q;
        neg = (num < 0) != (den < 0);
        lim = (64'd1 << 31) - (neg ? 64'd0 : 64'd1);
        if (magnitude(den) == 0) q = '1;
        else q = ({64'd0, magnitude(num)} << QRS_FRAC_BITS) / {64'd0, magnitude(den)};
        if (q[127:64] != 0 || q[63:0] > lim) begin
            qq = lim;
            sat = 1'b1;
        end else begin
            qq = q[63:0];
        end
        if (qq == 0) neg = 1'b0;
        return neg ? 32'd0 - qq[31:0] : qq[31:0];
    endfunction

    function automatic roots_t solve_roots(logic signed [31:0] ca, logic signed [31:0] cb,
                                           logic signed [31:0] cc, logic [15:0] tol);
        roots_t       r;
        longint       a;
        longint       b;
        longint       c;
        longint       a2;
        longint       s;
        logic [127:0] bb;
        logic [127:0] ac4;
        logic [127:0] dmag;
        logic         dneg;
        logic         sat;
        a = ca;
        b = cb;
        c = cc;
        a2 = a * 2;
        sat = 1'b0;
        r.kind = KIND_NONE;
        r.one = '0;
        r.two = '0;
        if (magnitude(a) <= tol) begin
            // Linear case.
            if (magnitude(b) > tol) begin
                r.kind = KIND_ONE;
                r.one = fixed_quotient(-c, b, sat);
            end else if (magnitude(c) > tol) begin
                r.kind = KIND_NONE;
            end else begin
                r.kind = KIND_INF;
            end
        end else begin
            // Exact discriminant magnitude and sign at double width.
            bb = {64'd0, magnitude(b)} * {64'd0, magnitude(b)};
            ac4 = ({64'd0, magnitude(a)} * {64'd0, magnitude(c)}) << 2;
            if (((a < 0) != (c < 0)) && ac4 != 0) begin
                dmag = bb + ac4;
                dneg = 1'b0;
            end else if (bb >= ac4) begin
                dmag = bb - ac4;
                dneg = 1'b0;
            end else begin
                dmag = ac4 - bb;
                dneg = 1'b1;
            end
            if (dmag <= ({112'd0, tol} << QRS_FRAC_BITS)) begin
                r.kind = KIND_ONE;
                r.one = fixed_quotient(-b, a2, sat);
            end else begin
                s = root_floor(dmag);
                if (!dneg) begin
                    r.kind = KIND_TWO;
                    r.one = fixed_quotient(-b + s, a2, sat);
                    r.two = fixed_quotient(-b - s, a2, sat);
                end else begin
                    r.kind = KIND_COMPLEX;
                    r.one = fixed_quotient(-b, a2, sat);
                    r.two = fixed_quotient(s, a2 < 0 ? -a2 : a2, sat);
                end
            end
        end
        r.sat = sat;
        return r;
    endfunction

    // Track config writes, predict on every input beat, check every result beat.
    always @(posedge aclk) begin
        roots_t want;
        if (!aresetn) begin
            expected_roots.delete();
            tolerance <= '0;
            mismatches <= 0;
            checked <= 0;
        end else begin
            if (cfg_valid && cfg_ready) tolerance <= cfg_data;
            if (s_valid && s_ready)
                expected_roots.push_back(solve_roots(s_coef_a, s_coef_b, s_coef_c, tolerance));
            if (m_valid && m_ready) begin
                if (expected_roots.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Unexpected result beat: kind %0d one %h two %h sat %0d",
                                 m_root_kind, m_root_one, m_root_two, m_saturated);
                end else begin
                    want = expected_roots.pop_front();
                    checked <= checked + 1;
                    if (want.kind !== m_root_kind || want.one !== m_root_one ||
                        want.two !== m_root_two || want.sat !== m_saturated) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"Mismatch: expected kind %0d one %h two %h sat %0d,",
                                      " got kind %0d one %h two %h sat %0d"},
                                     want.kind, want.one, want.two, want.sat,
                                     m_root_kind, m_root_one, m_root_two, m_saturated);
                    end
                end
            end
        end
    end
endmodule

[test/testbench.sv]
// Top of the quadratic root solver test: clock, reset, stimulus phases and verdict.
// Depends on qrs_pkg, quadratic_root_solver_unit and qrs_checker.
module testbench;
    import qrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 200;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [QRS_TOL_WIDTH-1:0]         cfg_data = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic signed [QRS_DATA_WIDTH-1:0] s_coef_a = '0;
    logic signed [QRS_DATA_WIDTH-1:0] s_coef_b = '0;
    logic signed [QRS_DATA_WIDTH-1:0] s_coef_c = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [2:0]                       m_root_kind;
    logic signed [QRS_DATA_WIDTH-1:0] m_root_one;
    logic signed [QRS_DATA_WIDTH-1:0] m_root_two;
    logic                             m_saturated;
    int                               fail_count;
    int                               roots_pending;
    int                               roots_checked;
    int                               cycle_count = 0;
    int                               send_idle_pct = 0;
    int                               recv_stall_pct = 0;
    int                               sets_sent = 0;
    int                               tol_writes = 0;
    logic [QRS_TOL_WIDTH-1:0]         tol_now = '0;

    quadratic_root_solver_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready), .m_root_kind(m_root_kind),
        .m_root_one(m_root_one), .m_root_two(m_root_two), .m_saturated(m_saturated)
    );

    qrs_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready), .m_root_kind(m_root_kind),
        .m_root_one(m_root_one), .m_root_two(m_root_two), .m_saturated(m_saturated),
        .fail_count(fail_count), .roots_pending(roots_pending),
        .roots_checked(roots_checked)
    );

    // Clock with a 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Present one coefficient set and hold it until the beat is taken.
    task automatic send_set(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sets_sent++;
    endtask

    // Wait for every result to come back, then let the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (roots_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the tolerance register while the block is idle.
    task automatic write_tolerance(logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tol_now = value;
        tol_writes++;
    endtask

    // A signed value whose magnitude lies close to the tolerance.
    function automatic logic [31:0] near_tol();
        int m;
        m = $urandom_range(0, tol_now + 2);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // Random coefficient sets: mostly shaped so every root kind shows up.
    task automatic send_random_set();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        int          r1;
        int          r2;
        int          k;
        case ($urandom_range(0, 7))
            0, 1: begin
                a = $urandom();
                b = $urandom();
                c = $urandom();
            end
            2: begin
                // Small coefficients within +-16.
                a = $signed($urandom_range(0, 32 << 16)) - (16 << 16);
                b = $signed($urandom_range(0, 32 << 16)) - (16 << 16);
                c = $signed($urandom_range(0, 32 << 16)) - (16 << 16);
            end
            3, 4: begin
                // Integer roots r1, r2 from k*(x-r1)*(x-r2); equal roots now and then.
                k = $signed($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
                r1 = $signed($urandom_range(0, 40)) - 20;
                r2 = $urandom_range(0, 3) == 0 ? r1 : $signed($urandom_range(0, 40)) - 20;
                a = k << 16;
                b = (-k * (r1 + r2)) << 16;
                c = (k * r1 * r2) << 16;
            end
            5: begin
                // Linear and degenerate sets around the zero threshold.
                a = near_tol();
                b = $urandom_range(0, 1) ? near_tol() : $urandom();
                c = $urandom_range(0, 1) ? near_tol() : $urandom();
            end
            6: begin
                // Tiny a with large b and c forces saturated roots.
                a = $urandom_range(0, 1) ? tol_now + 1 : -(tol_now + 1);
                b = $urandom();
                c = $urandom();
            end
            default: begin
                // Same sign a and c with small b: complex pairs.
                k = $urandom_range(1, 1 << 20);
                a = $urandom_range(0, 1) ? k : -k;
                c = a[31] ? -$signed($urandom_range(1, 1 << 22)) : $urandom_range(1, 1 << 22);
                b = $signed($urandom_range(0, 1 << 12)) - (1 << 11);
            end
        endcase
        send_set(a, b, c);
    endtask

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) send_random_set();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sets at tolerance zero.
        send_set(32'h0, 32'h0, 32'h0);                  // infinitely many roots
        send_set(32'h0, 32'h0, 32'h0001_0000);          // no root
        send_set(32'h0, 32'h0002_0000, 32'hFFFC_0000);  // linear, root 2
        send_set(32'h0, 32'h0000_0001, 32'h7FFF_FFFF);  // linear, saturated
        send_set(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000); // double root 1
        send_set(32'h0001_0000, 32'h0, 32'hFFFC_0000);  // roots +-2
        send_set(32'h0001_0000, 32'h0, 32'h0004_0000);  // complex +-2i
        send_set(32'h0001_0000, 32'h0002_0000, 32'h0005_0000); // -1 +- 2i
        send_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_set(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_set(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000); // tiny a, saturated
        send_set(32'hFFFF_FFFF, 32'h0, 32'h0);          // one root at zero
        send_set(32'hFFFF_0000, 32'h0003_0000, 32'h0);  // roots 0 and 3
        send_set(32'h0, 32'h8000_0000, 32'h8000_0000);
        send_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_set(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_set(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        // Largest tolerance: small values collapse to zero.
        write_tolerance(16'hFFFF);
        send_set(32'h0000_FFFF, 32'hFFFF_0001, 32'h0000_FFFF); // all near zero
        send_set(32'h0000_FFFF, 32'h0001_0000, 32'h0);         // linear
        send_set(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0080); // discriminant in tolerance
        random_phase(200, 0, 0);

        write_tolerance(16'd0);
        random_phase(350, 0, 0);
        random_phase(150, 73, 0);
        // Let the pipeline empty once in the middle of the stream.
        drain();
        random_phase(150, 73, 0);

        write_tolerance(16'd3);
        random_phase(300, 0, 73);

        write_tolerance($urandom_range(1, 65534));
        random_phase(300, 9, 9);

        write_tolerance(16'd1000);
        random_phase(300, 0, 0);

        drain();
        if (roots_pending != 0) $display("%0d results never arrived.", roots_pending);
        $display("Sent %0d coefficient sets and checked %0d results over %0d tolerance settings,",
                 sets_sent, roots_checked, tol_writes + 1);
        $display("with sender gaps and receiver stalls in separate and mixed phases.");
        if (fail_count == 0 && roots_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[quadratic_root_solver_unit.f]
rtl/qrs_pkg.sv
rtl/qrs_div.sv
rtl/qrs_front.sv
rtl/qrs_fifo.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver_unit.sv
test/qrs_checker.sv
test/testbench.sv
